>>> design/qclc_pkg.sv
// Package: shared types, codes and conversion functions for the chunk layout converter.
package qclc_pkg;

   localparam int CmdWidth   = 2;
   localparam int RowWidth   = 14;
   localparam int ColWidth   = 10;
   localparam int PlaneWidth = 3;
   localparam int DataWidth  = 32;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 16;

   localparam logic [CmdWidth-1:0] CMD_SIGN  = 2'd0;
   localparam logic [CmdWidth-1:0] CMD_SCALE = 2'd1;
   localparam logic [CmdWidth-1:0] CMD_BIAS  = 2'd2;

   localparam logic [CsrIdxWidth-1:0] REG_ROW_COUNT         = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_GROUP_COUNT       = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_TILE_COUNT        = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_SIGN_PLANE_COUNT  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_SCALE_PLANE_COUNT = 3'd4;
   localparam logic [CsrIdxWidth-1:0] REG_SCALE_IS_HALF     = 3'd5;
   localparam logic [CsrIdxWidth-1:0] REG_BIAS_IS_HALF      = 3'd6;

   localparam logic [30:0] F32_HALF_OVF  = 31'h47800000;
   localparam logic [30:0] F32_HALF_MIN  = 31'h38800000;
   localparam logic [30:0] F32_EXP_REBIAS = 31'h38000000;
   localparam logic [30:0] F32_INF       = 31'h7f800000;
   localparam logic [30:0] F32_RND_BIAS  = 31'h00000fff;
   localparam logic [14:0] F16_INF       = 15'h7c00;

   typedef struct packed {
      logic [CmdWidth-1:0]   command;
      logic [RowWidth-1:0]   row_index;
      logic [ColWidth-1:0]   column_index;
      logic [PlaneWidth-1:0] plane_index;
      logic [DataWidth-1:0]  raw_data;
   } req_type;

   typedef struct packed {
      logic [31:0] byte_offset;
      logic [31:0] out_data;
      logic        is_word;
   } rsp_type;

   typedef struct packed {
      logic [14:0] row_count;
      logic [10:0] group_count;
      logic [10:0] tile_count;
      logic [3:0]  sign_plane_count;
      logic [3:0]  scale_plane_count;
      logic        scale_is_half;
      logic        bias_is_half;
   } cfg_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   function automatic logic [31:0] reverse_byte_bits(input logic [31:0] w);
      logic [31:0] r;
      r = '0;
      for (int k = 0; k < 32; k++) begin
         r[k] = w[(k / 8) * 8 + (7 - (k % 8))];
      end
      return r;
   endfunction

   function automatic logic [15:0] single_to_half(input logic [31:0] u);
      logic        sign;
      logic [30:0] x;
      logic [7:0]  e;
      logic [23:0] m;
      logic [7:0]  s;
      logic [23:0] q;
      logic [23:0] rem;
      logic [23:0] half;
      logic [30:0] t;
      logic [15:0] r;
      sign = u[31];
      x    = u[30:0];
      e    = x[30:23];
      m    = {1'b1, x[22:0]};
      s    = 8'd126 - e;
      q    = m >> s[4:0];
      rem  = m & ((24'd1 << s[4:0]) - 24'd1);
      half = 24'd1 << (s[4:0] - 5'd1);
      t    = x - F32_EXP_REBIAS + F32_RND_BIAS + {30'd0, x[13]};
      if (x > F32_INF) begin
         r = {sign, 5'h1f, 1'b1, u[21:13]};
      end else if (x >= F32_HALF_OVF) begin
         r = {sign, F16_INF};
      end else if (x < F32_HALF_MIN) begin
         if (e == 8'd0 || s > 8'd24) begin
            r = {sign, 15'd0};
         end else begin
            if (rem > half || (rem == half && q[0])) begin
               q = q + 24'd1;
            end
            r = {sign, q[14:0]};
         end
      end else begin
         r = {sign, t[27:13]};
      end
      return r;
   endfunction

endpackage

>>> design/qclc_offset.sv
// Byte offset pipeline: index products, plane products, final sum.
module qclc_offset
   import qclc_pkg::*;
(
   input  logic                  clock,
   input  stage_en_type          en,
   input  cfg_type               cfg,
   input  req_type               req,
   output logic [31:0]           byte_offset
);

   logic [CmdWidth-1:0]   cmd1_ff, cmd1_in, cmd2_ff, cmd2_in;
   logic [RowWidth-1:0]   row1_ff, row1_in;
   logic [PlaneWidth-1:0] plane1_ff, plane1_in;
   logic [24:0]           cn1_ff, cn1_in;
   logic [25:0]           tn1_ff, tn1_in;
   logic [25:0]           gn1_ff, gn1_in;
   logic [31:0]           idx2_ff, idx2_in;
   logic [31:0]           ta2_ff, ta2_in;
   logic [31:0]           tb2_ff, tb2_in;
   logic [31:0]           off3_ff, off3_in;
   logic [27:0]           qw;
   logic [26:0]           alpha;
   logic [25:0]           lin;
   logic [3:0]            mult_a;
   logic [3:0]            mult_b;

   always_comb begin
      cmd1_in   = req.command;
      row1_in   = req.row_index;
      plane1_in = req.plane_index;
      cn1_in    = {15'd0, req.column_index} * {10'd0, cfg.row_count};
      tn1_in    = {15'd0, cfg.tile_count} * {11'd0, cfg.row_count};
      gn1_in    = {15'd0, cfg.group_count} * {11'd0, cfg.row_count};
   end

   always_comb begin
      qw     = {tn1_ff, 2'b00};
      alpha  = {gn1_ff, 1'b0};
      lin    = {1'b0, cn1_ff} + {12'd0, row1_ff};
      mult_a = (cmd1_ff == CMD_SIGN) ? {1'b0, plane1_ff} : cfg.sign_plane_count;
      mult_b = (cmd1_ff == CMD_SCALE) ? {1'b0, plane1_ff} : cfg.scale_plane_count;
      cmd2_in = cmd1_ff;
      ta2_in  = 32'({4'd0, qw} * {28'd0, mult_a});
      tb2_in  = 32'd0;
      idx2_in = 32'd0;
      case (cmd1_ff) inside
         CMD_SIGN: begin
            idx2_in = {4'd0, lin, 2'b00};
         end
         CMD_SCALE, CMD_BIAS: begin
            tb2_in  = 32'({5'd0, alpha} * {28'd0, mult_b});
            idx2_in = {5'd0, lin, 1'b0};
         end
         default: begin
            ta2_in = 32'd0;
         end
      endcase
   end

   always_comb begin
      off3_in = ta2_ff + tb2_ff + idx2_ff;
      if (cmd2_ff != CMD_SIGN && cmd2_ff != CMD_SCALE && cmd2_ff != CMD_BIAS) begin
         off3_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         cmd1_ff   <= cmd1_in;
         row1_ff   <= row1_in;
         plane1_ff <= plane1_in;
         cn1_ff    <= cn1_in;
         tn1_ff    <= tn1_in;
         gn1_ff    <= gn1_in;
      end
      if (en.s2) begin
         cmd2_ff <= cmd2_in;
         ta2_ff  <= ta2_in;
         tb2_ff  <= tb2_in;
         idx2_ff <= idx2_in;
      end
      if (en.s3) begin
         off3_ff <= off3_in;
      end
   end

   assign byte_offset = off3_ff;

endmodule

>>> design/qclc_data.sv
// Data pipeline: sign byte reversal, half pass-through or single-to-half rounding.
module qclc_data
   import qclc_pkg::*;
(
   input  logic         clock,
   input  stage_en_type en,
   input  cfg_type      cfg,
   input  req_type      req,
   output logic [31:0]  out_data,
   output logic         is_word
);

   logic [31:0] data1_ff, data1_in, data2_ff, data3_ff;
   logic        word1_ff, word1_in, word2_ff, word3_ff;
   logic [15:0] conv;

   always_comb begin
      conv     = single_to_half(req.raw_data);
      data1_in = 32'd0;
      word1_in = 1'b0;
      case (req.command)
         CMD_SIGN: begin
            data1_in = reverse_byte_bits(req.raw_data);
            word1_in = 1'b1;
         end
         CMD_SCALE: begin
            data1_in = {16'd0, cfg.scale_is_half ? req.raw_data[15:0] : conv};
         end
         CMD_BIAS: begin
            data1_in = {16'd0, cfg.bias_is_half ? req.raw_data[15:0] : conv};
         end
         default: begin
            data1_in = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         data1_ff <= data1_in;
         word1_ff <= word1_in;
      end
      if (en.s2) begin
         data2_ff <= data1_ff;
         word2_ff <= word1_ff;
      end
      if (en.s3) begin
         data3_ff <= data2_ff;
         word3_ff <= word2_ff;
      end
   end

   assign out_data = data3_ff;
   assign is_word  = word3_ff;

endmodule

>>> design/quant_chunk_layout_converter_core.sv
// Top level: config registers, stage valids and handshakes of the layout converter.
//
//  channel  direction  ports                          transaction
//  req      in         req_valid/ready, req_data      one stored element
//  rsp      out        rsp_valid/ready, rsp_data      converted element and offset
//  csr      in         csr_valid/ready, csr_index/wdata  register write
//
// Three register stages; one transaction per cycle sustained while rsp_ready is high.
// Stage 1 holds the index multiplies and the float conversion, stage 2 the plane
// multiplies, stage 3 the offset sum and the output register.
// Each stage loads when it is empty or the next stage moves; a stalled rsp holds.
// Reset clears the stage valids and loads all counts to 1 and both half flags.
module quant_chunk_layout_converter_core
   import qclc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIdxWidth-1:0]   csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   logic         v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic         rdy1, rdy2, rdy3;
   stage_en_type en;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_ROW_COUNT:         cfg_in.row_count         = csr_wdata[14:0];
            REG_GROUP_COUNT:       cfg_in.group_count       = csr_wdata[10:0];
            REG_TILE_COUNT:        cfg_in.tile_count        = csr_wdata[10:0];
            REG_SIGN_PLANE_COUNT:  cfg_in.sign_plane_count  = csr_wdata[3:0];
            REG_SCALE_PLANE_COUNT: cfg_in.scale_plane_count = csr_wdata[3:0];
            REG_SCALE_IS_HALF:     cfg_in.scale_is_half     = csr_wdata[0];
            REG_BIAS_IS_HALF:      cfg_in.bias_is_half      = csr_wdata[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      rdy3 = !v3_ff || rsp_ready;
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;
      en.s1 = rdy1 && req_valid;
      en.s2 = rdy2 && v1_ff;
      en.s3 = rdy3 && v2_ff;
      v1_in = rdy1 ? req_valid : v1_ff;
      v2_in = rdy2 ? v1_ff : v2_ff;
      v3_in = rdy3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         cfg_ff <= '{row_count: 15'd1, group_count: 11'd1, tile_count: 11'd1,
                     sign_plane_count: 4'd1, scale_plane_count: 4'd1,
                     scale_is_half: 1'b1, bias_is_half: 1'b1};
      end else begin
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         v3_ff  <= v3_in;
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready = rdy1;
   assign rsp_valid = v3_ff;

   qclc_offset u_offset (
      .clock       (clock),
      .en          (en),
      .cfg         (cfg_ff),
      .req         (req_data),
      .byte_offset (rsp_data.byte_offset)
   );

   qclc_data u_data (
      .clock    (clock),
      .en       (en),
      .cfg      (cfg_ff),
      .req      (req_data),
      .out_data (rsp_data.out_data),
      .is_word  (rsp_data.is_word)
   );

endmodule
